[rtl/lpr_pkg.sv]
package lpr_pkg;

   // table sizing
   localparam int TABLE_DEPTH = 32;
   localparam int NUM_PORTS   = 16;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // stream widths (payload padded to whole bytes)
   localparam int REQ_DATA_W = 120;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 3;

   // command kinds carried in req_tuser
   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_ROUTE = 1'b1;

   // result status codes carried in rsp_tuser
   localparam logic [2:0] ST_ADDED   = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_FORWARD = 3'd2;
   localparam logic [2:0] ST_NOROUTE = 3'd3;
   localparam logic [2:0] ST_EXPIRED = 3'd4;

   typedef struct packed {
      logic [31:0] prefix;
      logic [5:0]  len;
      logic [31:0] hop;
      logic        direct;
      logic [3:0]  port;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // latch request word, clear scan state
      logic add;    // store route if room and port valid
      logic step;   // read entry at scan index, advance
      logic emit;   // load result into output register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;  // scan index reached entry count
      logic out_busy;   // output register holds an untaken word
   } dp_sts_type;

endpackage

[rtl/lpr_ctrl.sv]
module lpr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_cmd,
   input  lpr_pkg::dp_sts_type   sts,
   output lpr_pkg::dp_cmd_type   cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ADD   = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = (req_cmd == lpr_pkg::CMD_ADD) ? S_ADD : S_SCAN;
            end
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            state_in = S_EMIT;
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               state_in = S_DRAIN;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_DRAIN: begin
            // last entry was compared in the final scan cycle; best match is settled
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/lpr_dp.sv]
module lpr_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [lpr_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [lpr_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lpr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [lpr_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input  lpr_pkg::dp_cmd_type               cmd,
   output lpr_pkg::dp_sts_type               sts
);

   // route storage
   lpr_pkg::entry_type entry_mem [lpr_pkg::TABLE_DEPTH];

   // latched request
   logic [31:0] pfx_ff, hop_ff, dst_ff;
   logic [5:0]  len_ff;
   logic        has_hop_ff;
   logic [3:0]  port_ff;
   logic [7:0]  ttl_ff;
   logic        is_add_ff;

   // table and scan state
   logic [lpr_pkg::CNT_W-1:0] count_ff, count_in;
   logic [lpr_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic                      rd_valid_ff;
   lpr_pkg::entry_type        rd_entry_ff;
   logic                      add_ok_ff, add_ok_in;

   // best match so far
   logic        found_ff, found_in;
   logic [5:0]  best_len_ff, best_len_in;
   logic [3:0]  best_port_ff, best_port_in;
   logic [31:0] best_hop_ff, best_hop_in;
   logic        best_direct_ff, best_direct_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [3:0]  rsp_port_ff, rsp_port_in;
   logic [31:0] rsp_hop_ff, rsp_hop_in;
   logic [7:0]  rsp_ttl_ff, rsp_ttl_in;

   logic        room;
   logic        port_ok;
   logic [31:0] mask;
   logic        hit;
   logic        better;

   assign room    = (count_ff < lpr_pkg::CNT_W'(lpr_pkg::TABLE_DEPTH));
   assign port_ok = (32'(port_ff) < lpr_pkg::NUM_PORTS);

   // prefix match on the entry read last cycle
   assign mask   = ~(32'hFFFF_FFFF >> rd_entry_ff.len);
   assign hit    = rd_valid_ff && (rd_entry_ff.len <= 6'd32)
                   && (((rd_entry_ff.prefix ^ dst_ff) & mask) == 32'd0);
   assign better = !found_ff || (rd_entry_ff.len > best_len_ff)
                   || ((rd_entry_ff.len == best_len_ff) && (rd_entry_ff.port >= best_port_ff));

   assign sts.scan_done = (idx_ff == count_ff);
   assign sts.out_busy  = rsp_valid_ff && !rsp_tready;

   always_comb begin
      count_in       = count_ff;
      idx_in         = idx_ff;
      add_ok_in      = add_ok_ff;
      found_in       = found_ff;
      best_len_in    = best_len_ff;
      best_port_in   = best_port_ff;
      best_hop_in    = best_hop_ff;
      best_direct_in = best_direct_ff;

      if (cmd.load) begin
         idx_in   = '0;
         found_in = 1'b0;
      end
      if (cmd.add) begin
         add_ok_in = room && port_ok;
         if (room && port_ok) begin
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.step) begin
         idx_in = idx_ff + 1'b1;
      end
      if (hit && better) begin
         found_in       = 1'b1;
         best_len_in    = rd_entry_ff.len;
         best_port_in   = rd_entry_ff.port;
         best_hop_in    = rd_entry_ff.hop;
         best_direct_in = rd_entry_ff.direct;
      end
   end

   // result word
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_port_in   = rsp_port_ff;
      rsp_hop_in    = rsp_hop_ff;
      rsp_ttl_in    = rsp_ttl_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_port_in  = 4'd0;
         rsp_hop_in   = 32'd0;
         rsp_ttl_in   = 8'd0;
         if (is_add_ff) begin
            rsp_status_in = add_ok_ff ? lpr_pkg::ST_ADDED : lpr_pkg::ST_FULL;
         end else if (!found_ff) begin
            rsp_status_in = lpr_pkg::ST_NOROUTE;
         end else if (ttl_ff <= 8'd1) begin
            rsp_status_in = lpr_pkg::ST_EXPIRED;
         end else begin
            rsp_status_in = lpr_pkg::ST_FORWARD;
            rsp_port_in   = best_port_ff;
            rsp_hop_in    = best_direct_ff ? dst_ff : best_hop_ff;
            rsp_ttl_in    = ttl_ff - 8'd1;
         end
      end
   end

   // request latch and payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pfx_ff     <= req_tdata[31:0];
         len_ff     <= req_tdata[37:32];
         has_hop_ff <= req_tdata[38];
         hop_ff     <= req_tdata[70:39];
         port_ff    <= req_tdata[74:71];
         dst_ff     <= req_tdata[106:75];
         ttl_ff     <= req_tdata[114:107];
         is_add_ff  <= (req_tuser[0] == lpr_pkg::CMD_ADD);
      end
      add_ok_ff      <= add_ok_in;
      idx_ff         <= idx_in;
      best_len_ff    <= best_len_in;
      best_port_ff   <= best_port_in;
      best_hop_ff    <= best_hop_in;
      best_direct_ff <= best_direct_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_port_ff    <= rsp_port_in;
      rsp_hop_ff     <= rsp_hop_in;
      rsp_ttl_ff     <= rsp_ttl_in;
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.add && room && port_ok) begin
         entry_mem[count_ff[lpr_pkg::ADDR_W-1:0]] <= '{
            prefix: pfx_ff,
            len:    len_ff,
            hop:    has_hop_ff ? hop_ff : 32'd0,
            direct: !has_hop_ff,
            port:   port_ff
         };
      end
      if (cmd.step) begin
         rd_entry_ff <= entry_mem[idx_ff[lpr_pkg::ADDR_W-1:0]];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_valid_ff  <= cmd.step;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'd0, rsp_ttl_ff, rsp_hop_ff, rsp_port_ff};

endmodule

[rtl/ipv4_longest_prefix_router.sv]
// Flow: an add passes the idle, add and emit states into the output register; a route
//   passes idle, scan (one table entry read per cycle from the route RAM, over the routes
//   stored, up to 32), drain and emit. Emit waits while the output register is busy.
// One word in flight: req_tready rises again in the cycle the result first shows on rsp_tvalid.
// Reset (synchronous, active high) empties the table and the output register; entry
//   contents are not cleared, only the fill count.
module ipv4_longest_prefix_router (
   input  logic                              clock,
   input  logic                              reset,
   // request: tuser = command (0 add route, 1 route datagram)
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata, low bit up: route_prefix_addr[31:0], route_prefix_len[37:32],
   // route_has_hop[38], route_hop_addr[70:39], route_port[74:71],
   // dest_addr[106:75], ttl_in[114:107], zero pad[119:115]
   input  logic [lpr_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [lpr_pkg::REQ_USER_W-1:0]    req_tuser,   // command[0]
   // response
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata, low bit up: out_port[3:0], hop_addr[35:4], ttl_out[43:36], zero pad[47:44]
   output logic [lpr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [lpr_pkg::RSP_USER_W-1:0]    rsp_tuser    // status[2:0]
);

   lpr_pkg::dp_cmd_type cmd;
   lpr_pkg::dp_sts_type sts;

   // Sequencer: idle -> add -> emit, or idle -> scan (one entry per cycle, last
   // compare on the done cycle) -> drain (best match settles) -> emit. Emit waits for a
   // free output register.
   lpr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser[0]),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Route RAM, fill count, best-match tracker (longest length, then higher
   // port, then later entry) and the response register.
   lpr_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule
